[hdl/ppd_pkg.sv]
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared types and constants for the proportional power dispatch block:
// field widths, the share offset, the datapath operation select and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ppd_pkg;

   // report and result field widths
   localparam int FIELD_W   = 16;
   localparam int IDX_OUT_W = 5;

   // quotient width of the shared divider and its step counter
   localparam int QUO_W     = 16;
   localparam int QUO_CNT_W = 5;

   // power codes carry an offset of 100, shares are reported with it
   localparam int SHARE_OFS = 100;
   localparam int SHARE_MAX = 65535;

   // share the shared arithmetic is working on
   typedef enum logic {
      OP_ACTIVE   = 1'b0,
      OP_REACTIVE = 1'b1
   } op_type;

   // controller to datapath
   typedef struct packed {
      logic   load;        // accumulate one report
      logic   mul;         // register total power times device weight
      logic   num;         // register share numerator
      logic   div_start;   // launch the divider
      logic   capture;     // store the share for sel
      logic   next_dev;    // advance to the next device's result
      logic   clear;       // end of round, clear sums
      op_type sel;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_slot;     // the next report completes the round
      logic div_done;      // quotient is ready
      logic last_dev;      // current result is for the final device
   } sts_type;

endpackage

`default_nettype wire

[hdl/ppd_divider.sv]
// ----------------------------------------------------------------------------
// ppd_divider
// Restoring divider, one quotient bit per cycle. Produces a QUO_W-bit
// quotient; the caller guarantees the quotient fits (the upper DIV_W bits of
// the dividend are below the divisor).
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_divider #(
   parameter int DIV_W = 18
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [DIV_W+ppd_pkg::QUO_W-1:0] dividend,
   input  wire logic [DIV_W-1:0]              divisor,
   output logic      [ppd_pkg::QUO_W-1:0]     quotient,
   output logic                               busy,
   output logic                               done
);
   import ppd_pkg::*;

   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     dvs_ff, dvs_in;
   logic [QUO_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_W:0]       trial;
   logic                 fits;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[DIV_W+QUO_W-1:QUO_W];
         quo_in  = dividend[QUO_W-1:0];
         dvs_in  = divisor;
         cnt_in  = QUO_CNT_W'(QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_W'(trial - {1'b0, dvs_ff}) : trial[DIV_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == QUO_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign busy     = busy_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

[hdl/ppd_datapath.sv]
// ----------------------------------------------------------------------------
// ppd_datapath
// Round accumulators, per-device weight store, share multiplier and the
// shared divider, plus the result registers that drive the rsp_ fields.
// The means come from a reciprocal multiply of the code sums.
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_datapath #(
   parameter int DEVICE_COUNT = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ppd_pkg::cmd_type                  cmd,
   output ppd_pkg::sts_type                       sts,
   input  wire logic [ppd_pkg::FIELD_W-1:0]       req_voltage_code,
   input  wire logic [ppd_pkg::FIELD_W-1:0]       req_frequency_code,
   input  wire logic [ppd_pkg::FIELD_W-1:0]       req_active_power_code,
   input  wire logic [ppd_pkg::FIELD_W-1:0]       req_reactive_power_code,
   input  wire logic [ppd_pkg::FIELD_W-1:0]       req_active_weight,
   input  wire logic [ppd_pkg::FIELD_W-1:0]       req_reactive_weight,
   output logic      [ppd_pkg::IDX_OUT_W-1:0]     rsp_device_index,
   output logic      [ppd_pkg::FIELD_W-1:0]       rsp_voltage_setpoint,
   output logic      [ppd_pkg::FIELD_W-1:0]       rsp_frequency_setpoint,
   output logic      [ppd_pkg::FIELD_W-1:0]       rsp_active_share,
   output logic      [ppd_pkg::FIELD_W-1:0]       rsp_reactive_share,
   output logic                                   rsp_weight_fault,
   output logic                                   rsp_last_result
);
   import ppd_pkg::*;

   localparam int SUM_W = FIELD_W + $clog2(DEVICE_COUNT);
   localparam int IDX_W = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
   localparam int DVD_W = SUM_W + QUO_W;
   localparam int NUM_W = SUM_W + FIELD_W + 2;
   localparam logic [IDX_W-1:0]       LAST_IDX = IDX_W'(DEVICE_COUNT - 1);
   localparam logic signed [SUM_W:0]  PWR_OFS  = (SUM_W+1)'(SHARE_OFS * DEVICE_COUNT);
   // sum / N as (sum * ceil(2^K / N)) >> K, exact for every sum below 2^SUM_W
   localparam int MEAN_K  = SUM_W + $clog2(DEVICE_COUNT);
   localparam int MPROD_W = SUM_W + MEAN_K + 1;
   localparam logic [MEAN_K:0] MEAN_RCP =
      (MEAN_K+1)'(((64'd1 << MEAN_K) + 64'(DEVICE_COUNT) - 64'd1) / 64'(DEVICE_COUNT));

   // round sums
   logic [SUM_W-1:0] vsum_ff, fsum_ff, psum_ff, qsum_ff, wpsum_ff, wqsum_ff;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [IDX_W-1:0] dev_ff, dev_in;

   // per-device weights, valid once loaded in the round
   logic [FIELD_W-1:0] wp_store [DEVICE_COUNT];
   logic [FIELD_W-1:0] wq_store [DEVICE_COUNT];

   logic signed [NUM_W-1:0] prod_ff, num_ff;
   logic [FIELD_W-1:0]      vmean_ff, fmean_ff, pshare_ff, qshare_ff;
   logic [FIELD_W-1:0]      vmean_in, fmean_in;
   logic [MPROD_W-1:0]      vprod, fprod;

   logic signed [SUM_W:0]   pwr_sel;
   logic [FIELD_W-1:0]      w_sel;
   logic [SUM_W-1:0]        wsum_sel;
   logic [DVD_W-1:0]        dividend;
   logic [SUM_W-1:0]        divisor;
   logic [QUO_W-1:0]        quotient;
   logic                    div_busy;
   logic                    div_done;
   logic                    num_pos;
   logic                    num_sat;
   logic [FIELD_W-1:0]      share_val;

   // slot and device pointers
   always_comb begin
      slot_in = slot_ff;
      dev_in  = dev_ff;
      if (cmd.load)
         slot_in = (slot_ff == LAST_IDX) ? '0 : slot_ff + 1'b1;
      if (cmd.next_dev)
         dev_in = dev_ff + 1'b1;
      if (cmd.clear) begin
         slot_in = '0;
         dev_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         dev_ff   <= '0;
         vsum_ff  <= '0;
         fsum_ff  <= '0;
         psum_ff  <= '0;
         qsum_ff  <= '0;
         wpsum_ff <= '0;
         wqsum_ff <= '0;
      end else begin
         slot_ff <= slot_in;
         dev_ff  <= dev_in;
         if (cmd.clear) begin
            vsum_ff  <= '0;
            fsum_ff  <= '0;
            psum_ff  <= '0;
            qsum_ff  <= '0;
            wpsum_ff <= '0;
            wqsum_ff <= '0;
         end else if (cmd.load) begin
            vsum_ff  <= vsum_ff  + SUM_W'(req_voltage_code);
            fsum_ff  <= fsum_ff  + SUM_W'(req_frequency_code);
            psum_ff  <= psum_ff  + SUM_W'(req_active_power_code);
            qsum_ff  <= qsum_ff  + SUM_W'(req_reactive_power_code);
            wpsum_ff <= wpsum_ff + SUM_W'(req_active_weight);
            wqsum_ff <= wqsum_ff + SUM_W'(req_reactive_weight);
         end
      end
   end

   // weight store, written at the load slot
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         wp_store[slot_ff] <= req_active_weight;
         wq_store[slot_ff] <= req_reactive_weight;
      end
   end

   // means: reciprocal multiply, settled long before the first result
   assign vprod    = MPROD_W'(vsum_ff) * MPROD_W'(MEAN_RCP);
   assign fprod    = MPROD_W'(fsum_ff) * MPROD_W'(MEAN_RCP);
   assign vmean_in = vprod[MEAN_K +: FIELD_W];
   assign fmean_in = fprod[MEAN_K +: FIELD_W];

   always_ff @(posedge clock) begin
      vmean_ff <= vmean_in;
      fmean_ff <= fmean_in;
   end

   // operand select for the quantity being worked on
   always_comb begin
      case (cmd.sel)
         OP_ACTIVE: begin
            pwr_sel  = $signed({1'b0, psum_ff}) - PWR_OFS;
            w_sel    = wp_store[dev_ff];
            wsum_sel = wpsum_ff;
         end
         default: begin
            pwr_sel  = $signed({1'b0, qsum_ff}) - PWR_OFS;
            w_sel    = wq_store[dev_ff];
            wsum_sel = wqsum_ff;
         end
      endcase
   end

   // numerator: total power times weight, then plus 100 times weight total
   always_ff @(posedge clock) begin
      if (cmd.mul)
         prod_ff <= pwr_sel * $signed({1'b0, w_sel});
      if (cmd.num)
         prod_ff <= prod_ff;
      if (cmd.num)
         num_ff <= prod_ff + $signed(NUM_W'(wsum_sel) * NUM_W'(SHARE_OFS));
   end

   // divider operands: numerator over weight total
   assign dividend = num_ff[DVD_W-1:0];
   assign divisor  = wsum_sel;

   ppd_divider #(
      .DIV_W (SUM_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .quotient (quotient),
      .busy     (div_busy),
      .done     (div_done)
   );

   // share: zero total, non-positive and out-of-range numerators bypass
   assign num_pos = !num_ff[NUM_W-1] && (num_ff != '0);
   assign num_sat = num_pos && ($unsigned(num_ff) >= (NUM_W'(wsum_sel) << QUO_W));

   always_comb begin
      if (wsum_sel == '0)
         share_val = FIELD_W'(SHARE_OFS);
      else if (!num_pos)
         share_val = '0;
      else if (num_sat)
         share_val = FIELD_W'(SHARE_MAX);
      else
         share_val = quotient;
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         case (cmd.sel)
            OP_ACTIVE:   pshare_ff <= share_val;
            OP_REACTIVE: qshare_ff <= share_val;
            default:     pshare_ff <= pshare_ff;
         endcase
      end
   end

   assign sts.last_slot = (slot_ff == LAST_IDX);
   assign sts.div_done  = div_done;
   assign sts.last_dev  = (dev_ff == LAST_IDX);

   assign rsp_device_index       = IDX_OUT_W'(dev_ff);
   assign rsp_voltage_setpoint   = vmean_ff;
   assign rsp_frequency_setpoint = fmean_ff;
   assign rsp_active_share       = pshare_ff;
   assign rsp_reactive_share     = qshare_ff;
   assign rsp_weight_fault       = (wpsum_ff == '0) || (wqsum_ff == '0);
   assign rsp_last_result        = sts.last_dev;

   // divider is launched only when idle
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider started while busy");

   // no report is loaded while a division is running
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !div_busy)
      else $error("report loaded during result computation");

endmodule

`default_nettype wire

[hdl/ppd_controller.sv]
// ----------------------------------------------------------------------------
// ppd_controller
// Sequencer for one round: takes reports until the last device, then runs,
// per device, the active and reactive shares through the shared divider
// and hands each result out.
// ----------------------------------------------------------------------------
`default_nettype none

module ppd_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ppd_pkg::cmd_type       cmd,
   input  wire ppd_pkg::sts_type  sts
);
   import ppd_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_NUM   = 6'b000100,
      ST_START = 6'b001000,
      ST_WAIT  = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   op_type    sel_ff, sel_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      cmd.sel   = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (sts.last_slot) begin
                  sel_in   = OP_ACTIVE;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_NUM;
         end
         ST_NUM: begin
            cmd.num  = 1'b1;
            state_in = ST_START;
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (sts.div_done) begin
               cmd.capture = 1'b1;
               case (sel_ff)
                  OP_ACTIVE: begin
                     sel_in   = OP_REACTIVE;
                     state_in = ST_MUL;
                  end
                  default: begin
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (sts.last_dev) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  cmd.next_dev = 1'b1;
                  sel_in       = OP_ACTIVE;
                  state_in     = ST_MUL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= OP_ACTIVE;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   // the final result's transfer closes the round
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && sts.last_dev) |=> (state_ff == ST_IDLE))
      else $error("round did not close after final result");

   // a result is only offered after a reactive share was captured
   a_out_after_share: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(cmd.capture) && ($past(sel_ff) == OP_REACTIVE)))
      else $error("result offered without a fresh share");

endmodule

`default_nettype wire

[hdl/proportional_power_dispatch_top.sv]
// ----------------------------------------------------------------------------
// proportional_power_dispatch_top
// Collects one report per device; after the last device of a round, emits
// one setpoint result per device: voltage and frequency means and the
// device's proportional share of total active and reactive power.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid/req_ready    six 16-bit report fields
//   rsp_     out        rsp_valid/rsp_ready    index, means, shares, flags
//
// The last report of a round starts the share sequence in the next cycle;
// the means come from a reciprocal multiply of the sums. Each device's
// result runs two shares, active then reactive, each through multiply,
// numerator, divider launch, 16 restoring steps and the done strobe, then
// its transfer. No report is taken while a round's results are being
// computed or delivered; rsp_ready low holds the current result. Reset
// (synchronous) clears the sums and sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module proportional_power_dispatch_top #(
   parameter int DEVICE_COUNT = 4
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [ppd_pkg::FIELD_W-1:0]     req_voltage_code,
   input  wire logic [ppd_pkg::FIELD_W-1:0]     req_frequency_code,
   input  wire logic [ppd_pkg::FIELD_W-1:0]     req_active_power_code,
   input  wire logic [ppd_pkg::FIELD_W-1:0]     req_reactive_power_code,
   input  wire logic [ppd_pkg::FIELD_W-1:0]     req_active_weight,
   input  wire logic [ppd_pkg::FIELD_W-1:0]     req_reactive_weight,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [ppd_pkg::IDX_OUT_W-1:0]   rsp_device_index,
   output logic      [ppd_pkg::FIELD_W-1:0]     rsp_voltage_setpoint,
   output logic      [ppd_pkg::FIELD_W-1:0]     rsp_frequency_setpoint,
   output logic      [ppd_pkg::FIELD_W-1:0]     rsp_active_share,
   output logic      [ppd_pkg::FIELD_W-1:0]     rsp_reactive_share,
   output logic                                 rsp_weight_fault,
   output logic                                 rsp_last_result
);
   import ppd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ppd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   ppd_datapath #(
      .DEVICE_COUNT (DEVICE_COUNT)
   ) u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .sts                     (sts),
      .req_voltage_code        (req_voltage_code),
      .req_frequency_code      (req_frequency_code),
      .req_active_power_code   (req_active_power_code),
      .req_reactive_power_code (req_reactive_power_code),
      .req_active_weight       (req_active_weight),
      .req_reactive_weight     (req_reactive_weight),
      .rsp_device_index        (rsp_device_index),
      .rsp_voltage_setpoint    (rsp_voltage_setpoint),
      .rsp_frequency_setpoint  (rsp_frequency_setpoint),
      .rsp_active_share        (rsp_active_share),
      .rsp_reactive_share      (rsp_reactive_share),
      .rsp_weight_fault        (rsp_weight_fault),
      .rsp_last_result         (rsp_last_result)
   );

   // reports and results never overlap within a round
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("report taken while a result is pending");

endmodule

`default_nettype wire
